// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: sv/aes_pkg.sv
// Package with the AES-128 CBC types, constants and byte functions.
`default_nettype none
package aes_pkg;
	localparam int NumRounds = 10;
	localparam int ByteCycles = 16;
	localparam logic [7:0] Poly = 8'h1b;
	localparam logic [7:0] HiBit = 8'h80;

	typedef enum logic [1:0] {
		REG_KEY_HIGH = 2'd0,
		REG_KEY_LOW = 2'd1,
		REG_IV_HIGH = 2'd2,
		REG_IV_LOW = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [63:0] plain_high;
		logic [63:0] plain_low;
		logic first_block;
	} in_item_t;

	typedef struct packed {
		logic [63:0] cipher_high;
		logic [63:0] cipher_low;
	} out_item_t;

	// Control from the sequencer to the key schedule and the byte-serial round datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic last_round;
		logic key_start;
		logic [3:0] round;
	} rnd_ctrl_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (((a & HiBit) != 8'h00) ? Poly : 8'h00);
	endfunction

	// Next round constant from the current one.
	function automatic logic [7:0] rcon_next(input logic [7:0] rc);
		return xtime(rc);
	endfunction
endpackage
`default_nettype wire

// File: sv/aes_keysched.sv
// Round key generator: one AES-128 key schedule step per round.
`default_nettype none
module aes_keysched (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire aes_pkg::rnd_ctrl_t ctrl,
	input  wire logic [127:0] key,
	output logic [127:0] round_key
);
	import aes_pkg::*;

	logic [127:0] rk_q;
	logic [7:0] rc_q;
	logic [31:0] w3_rot;
	logic [127:0] rk_next;

	// Schedule step: rotate, substitute, round constant, chain the words.
	always_comb begin
		w3_rot = {sbox(rk_q[23:16]) ^ rc_q, sbox(rk_q[15:8]), sbox(rk_q[7:0]),
			sbox(rk_q[31:24])};
		rk_next[127:96] = rk_q[127:96] ^ w3_rot;
		rk_next[95:64] = rk_q[95:64] ^ rk_next[127:96];
		rk_next[63:32] = rk_q[63:32] ^ rk_next[95:64];
		rk_next[31:0] = rk_q[31:0] ^ rk_next[63:32];
	end

	// Round constant and key registers load at key start and advance once per round.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= 8'h01;
		end else if (ctrl.key_start) begin
			rc_q <= 8'h01;
		end else if (ctrl.step && ctrl.round != 4'd0) begin
			rc_q <= rcon_next(rc_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.key_start) begin
			rk_q <= key;
		end else if (ctrl.step && ctrl.round != 4'd0) begin
			rk_q <= rk_next;
		end
	end

	assign round_key = (ctrl.round == 4'd0) ? rk_q : rk_next;
endmodule
`default_nettype wire

// File: sv/aes_round.sv
// Byte-serial round datapath: state bytes shift through one S-box each cycle.
`default_nettype none
module aes_round (
	input  wire logic clk,
	input  wire aes_pkg::rnd_ctrl_t ctrl,
	input  wire logic [3:0] byte_idx,
	input  wire logic [127:0] load_data,
	input  wire logic [127:0] round_key,
	output logic [127:0] state
);
	import aes_pkg::*;

	logic [127:0] st_q;
	logic [127:0] sub_q;
	logic [7:0] sb;
	logic [127:0] sr;
	logic [127:0] mixed;
	logic [1:0] r_i;
	logic [1:0] c_i;
	logic [3:0] src;

	// Column-major position of byte_idx in ShiftRows source order.
	always_comb begin
		r_i = byte_idx[1:0];
		c_i = byte_idx[3:2];
		src = {c_i + r_i, r_i};
		sb = sbox(st_q[127 - 8 * src -: 8]);
	end

	// MixColumns over the fully substituted state.
	always_comb begin
		sr = sub_q;
		for (int c = 0; c < 4; c++) begin
			logic [7:0] a0, a1, a2, a3, all;
			a0 = sr[127 - 32 * c -: 8];
			a1 = sr[119 - 32 * c -: 8];
			a2 = sr[111 - 32 * c -: 8];
			a3 = sr[103 - 32 * c -: 8];
			all = a0 ^ a1 ^ a2 ^ a3;
			mixed[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			mixed[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			mixed[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			mixed[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
	end

	// One substituted byte enters the shift register per cycle.
	always_ff @(posedge clk) begin
		sub_q <= {sub_q[119:0], sb};
	end

	// State register: load with the first key, then close each round.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			st_q <= load_data ^ round_key;
		end else if (ctrl.step) begin
			st_q <= (ctrl.last_round ? sub_q : mixed) ^ round_key;
		end
	end

	assign state = st_q;
endmodule
`default_nettype wire

// File: sv/aes128_cbc_encrypt.sv
// Top level of the AES-128 CBC encryptor: registers, sequencer and chaining.
//
//  channel  | signals                         | beat
//  in       | in_valid, in_ready, in_data     | one plaintext block and first flag
//  out      | out_valid, out_ready, out_data  | one ciphertext block
//  cfg      | cfg_we, cfg_index, cfg_data     | one 64-bit register write
//
// One block takes a load, then 10 rounds that each pass the sixteen state
// bytes one at a time through the byte-serial S-box and then close the round,
// and then a done state presents the result. The single S-box sets the pace.
// Reset clears control, key, IV and the chaining value. A stalled output holds
// the result and blocks the next input until it is taken.
`default_nettype none
`include "assert_macros.svh"
module aes128_cbc_encrypt (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire aes_pkg::in_item_t in_data,
	output logic out_valid,
	input  wire logic out_ready,
	output aes_pkg::out_item_t out_data,
	input  wire logic cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [63:0] cfg_data
);
	import aes_pkg::*;

	state_t state_q, state_d;
	logic [3:0] round_q, round_d;
	logic [4:0] cnt_q, cnt_d;
	logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
	logic [127:0] chain_q;
	rnd_ctrl_t ctrl;
	logic [127:0] round_key;
	logic [127:0] st;
	logic [127:0] load_data;
	logic in_fire;

	assign in_fire = in_valid && in_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
			iv_hi_q <= '0;
			iv_lo_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_KEY_HIGH: key_hi_q <= cfg_data;
				REG_KEY_LOW: key_lo_q <= cfg_data;
				REG_IV_HIGH: iv_hi_q <= cfg_data;
				REG_IV_LOW: iv_lo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign load_data = {in_data.plain_high, in_data.plain_low} ^
		(in_data.first_block ? {iv_hi_q, iv_lo_q} : chain_q);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			round_q <= round_d;
			cnt_q <= cnt_d;
		end
	end

	// Next state and datapath control.
	always_comb begin
		state_d = state_q;
		round_d = round_q;
		cnt_d = cnt_q;
		ctrl = '0;
		ctrl.round = round_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ctrl.round = 4'd0;
				if (in_valid) begin
					ctrl.load = 1'b1;
					ctrl.key_start = 1'b1;
					state_d = ST_ROUND;
					round_d = 4'd1;
					cnt_d = '0;
				end
			end
			ST_ROUND: begin
				if (cnt_q == 5'(ByteCycles)) begin
					ctrl.step = 1'b1;
					ctrl.last_round = (round_q == 4'(NumRounds));
					cnt_d = '0;
					if (round_q == 4'(NumRounds)) begin
						state_d = ST_DONE;
					end else begin
						round_d = round_q + 4'd1;
					end
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			ST_DONE: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Key register in the schedule loads on the same cycle as the state,
	// so the state load takes the raw key straight from the key registers.
	aes_keysched u_keysched (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.key({key_hi_q, key_lo_q}),
		.round_key(round_key)
	);

	aes_round u_round (
		.clk(clk),
		.ctrl(ctrl),
		.byte_idx(cnt_q[3:0]),
		.load_data(load_data),
		.round_key(ctrl.load ? {key_hi_q, key_lo_q} : round_key),
		.state(st)
	);

	// Chaining value follows each delivered ciphertext.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
		end else if (out_valid && out_ready) begin
			chain_q <= st;
		end
	end

	assign out_data.cipher_high = st[127:64];
	assign out_data.cipher_low = st[63:0];

	`ASSERT_IMPL(a_excl, in_ready, !out_valid)
	`ASSERT_NEXT(a_start, in_fire, state_q == ST_ROUND && round_q == 4'd1)
	`ASSERT_IMPL(a_round, state_q == ST_ROUND, round_q != 4'd0 && cnt_q <= 5'(ByteCycles))
endmodule
`default_nettype wire

// File: dv/aes128_cbc_encrypt_tb.sv
// Self-checking testbench for the AES-128 CBC encryptor.
`timescale 1ns / 100ps
`default_nettype none
module aes128_cbc_encrypt_tb;
	import aes_pkg::*;

	localparam int CycleLimit = 1200000;
	localparam int DrainCycles = 400;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [63:0] cfg_data;

	aes128_cbc_encrypt DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor state: registers and chaining value.
	logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
	logic [127:0] chain_q;

	in_item_t plain_queue[$];
	out_item_t cipher_queue[$];
	int error_count = 0;
	int cycle_count = 0;
	bit quiet_mode = 0;
	bit hold_sender = 0;
	logic in_ready_seen;

	// Clock with a 20 ns period.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [7:0] sbox_lut(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] gf_double(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte n of a 128-bit block, byte 0 most significant.
	function automatic logic [7:0] byte_at(input logic [127:0] v, input int n);
		return v[127 - 8 * n -: 8];
	endfunction

	// Enciphers one block with AES-128; the round keys come from the key argument.
	function automatic logic [127:0] aes_encipher(input logic [127:0] blk, input logic [127:0] key);
		logic [7:0] rk [176];
		logic [7:0] st [16];
		logic [7:0] tmp [16];
		logic [7:0] w [4];
		logic [7:0] f, rc, a0, a1, a2, a3, all;
		logic [127:0] res;
		for (int i = 0; i < 16; i++) rk[i] = byte_at(key, i);
		rc = 8'h01;
		for (int i = 4; i < 44; i++) begin
			for (int j = 0; j < 4; j++) w[j] = rk[(i - 1) * 4 + j];
			if ((i % 4) == 0) begin
				f = w[0];
				w[0] = sbox_lut(w[1]) ^ rc;
				w[1] = sbox_lut(w[2]);
				w[2] = sbox_lut(w[3]);
				w[3] = sbox_lut(f);
				rc = gf_double(rc);
			end
			for (int j = 0; j < 4; j++) rk[i * 4 + j] = rk[(i - 4) * 4 + j] ^ w[j];
		end
		for (int i = 0; i < 16; i++) st[i] = byte_at(blk, i) ^ rk[i];
		for (int r = 1; r <= 10; r++) begin
			// SubBytes and ShiftRows together.
			for (int c = 0; c < 4; c++)
				for (int q = 0; q < 4; q++)
					tmp[q + 4 * c] = sbox_lut(st[q + 4 * ((c + q) % 4)]);
			if (r < 10) begin
				for (int c = 0; c < 16; c += 4) begin
					a0 = tmp[c]; a1 = tmp[c + 1]; a2 = tmp[c + 2]; a3 = tmp[c + 3];
					all = a0 ^ a1 ^ a2 ^ a3;
					tmp[c] = a0 ^ all ^ gf_double(a0 ^ a1);
					tmp[c + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
					tmp[c + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
					tmp[c + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[16 * r + i];
		end
		for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = st[i];
		return res;
	endfunction

	// Predicts the ciphertext of one accepted block and advances the chain.
	task automatic predict_cipher(input in_item_t item);
		logic [127:0] x;
		out_item_t o;
		x = {item.plain_high, item.plain_low} ^
			(item.first_block ? {iv_hi_q, iv_lo_q} : chain_q);
		chain_q = aes_encipher(x, {key_hi_q, key_lo_q});
		o.cipher_high = chain_q[127:64];
		o.cipher_low = chain_q[63:0];
		cipher_queue.push_back(o);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s at cycle %0d: got %h, expected %h", what, cycle_count, got, want);
		error_count++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Field values biased toward the extremes.
	function automatic logic [63:0] pick64();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return rand64();
		endcase
	endfunction

	// Writes one register at a falling edge; the testbench only does this while idle.
	task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_KEY_HIGH: key_hi_q = val;
			REG_KEY_LOW: key_lo_q = val;
			REG_IV_HIGH: iv_hi_q = val;
			REG_IV_LOW: iv_lo_q = val;
		endcase
	endtask

	task automatic wait_idle();
		while (plain_queue.size() != 0 || in_valid || cipher_queue.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic add_block(input logic [63:0] hi, input logic [63:0] lo, input logic first);
		in_item_t it;
		it.plain_high = hi;
		it.plain_low = lo;
		it.first_block = first;
		plain_queue.push_back(it);
	endtask

	// Driver: presents queued blocks at the falling edge and holds them until taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready_seen) begin
				if (plain_queue.size() != 0 && !hold_sender &&
						(quiet_mode || $urandom_range(0, 99) >= 34)) begin
					in_data <= plain_queue.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= quiet_mode || $urandom_range(0, 99) >= 34;
		end
	end

	// Handshake seen at the last rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ready_seen <= 1'b0;
		end else begin
			in_ready_seen <= in_valid && in_ready;
		end
	end

	// Monitor: predicts on each accepted input beat, checks each output beat.
	always @(posedge clk) begin
		out_item_t want;
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (in_valid && in_ready) predict_cipher(in_data);
			if (out_valid && out_ready) begin
				if (cipher_queue.size() == 0) begin
					$display("unexpected output beat at cycle %0d", cycle_count);
					error_count++;
				end else begin
					want = cipher_queue.pop_front();
					if (out_data.cipher_high !== want.cipher_high)
						report_mismatch("cipher_high", out_data.cipher_high, want.cipher_high);
					if (out_data.cipher_low !== want.cipher_low)
						report_mismatch("cipher_low", out_data.cipher_low, want.cipher_low);
				end
			end
		end
		if (cycle_count >= CycleLimit) begin
			$display("timeout at cycle %0d", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Stimulus: directed blocks, then several phases of random messages.
	initial begin
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY_HIGH;
		cfg_data = '0;
		key_hi_q = '0; key_lo_q = '0; iv_hi_q = '0; iv_lo_q = '0;
		chain_q = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Chaining before any first block uses the cleared chain value.
		add_block('0, '0, 1'b0);
		add_block('1, '1, 1'b0);
		add_block('0, '0, 1'b1);
		wait_idle();

		// Known answer vector of the standard, then extreme keys.
		write_reg(REG_KEY_HIGH, 64'h2b7e151628aed2a6);
		write_reg(REG_KEY_LOW, 64'habf7158809cf4f3c);
		write_reg(REG_IV_HIGH, 64'h0001020304050607);
		write_reg(REG_IV_LOW, 64'h08090a0b0c0d0e0f);
		add_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 1'b1);
		add_block(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 1'b0);
		add_block('1, '0, 1'b0);
		add_block('0, '1, 1'b1);
		for (int b = 0; b < 64; b += 8)
			add_block(64'h1 << b, 64'h8000000000000000 >> b, b[3]);
		wait_idle();
		write_reg(REG_KEY_HIGH, '1);
		write_reg(REG_KEY_LOW, '1);
		write_reg(REG_IV_HIGH, '1);
		write_reg(REG_IV_LOW, '1);
		add_block('1, '1, 1'b1);
		add_block('0, '0, 1'b0);
		add_block('0, '0, 1'b1);
		wait_idle();

		// Random messages; one phase runs with no idling at all.
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_KEY_HIGH, pick64());
			write_reg(REG_KEY_LOW, pick64());
			write_reg(REG_IV_HIGH, pick64());
			write_reg(REG_IV_LOW, pick64());
			quiet_mode = (ph == 3);
			for (int n = 0; n < 110; ) begin
				int len;
				len = $urandom_range(1, 8);
				for (int k = 0; k < len; k++)
					add_block(pick64(), pick64(), k == 0 ? ($urandom_range(0, 9) != 0) : 1'b0);
				n += len;
				// In phase 5 only, once, hold the sender until all pending blocks have drained.
				if (ph == 5 && n > 50 && n - len <= 50) begin
					while (plain_queue.size() != 0 || in_valid) @(posedge clk);
					hold_sender = 1'b1;
					while (cipher_queue.size() != 0) @(posedge clk);
					hold_sender = 1'b0;
				end
			end
			wait_idle();
			quiet_mode = 1'b0;
		end

		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
`default_nettype wire

// File: files.f
+incdir+sv
sv/aes_pkg.sv
sv/aes_keysched.sv
sv/aes_round.sv
sv/aes128_cbc_encrypt.sv
dv/aes128_cbc_encrypt_tb.sv
